@@ rtl/accumulator_machine_execute_unit_macros.svh @@
// Assertion helpers for the RTL files; amx_ctrl includes them.
`ifndef ACCUMULATOR_MACHINE_EXECUTE_UNIT_MACROS_SVH
`define ACCUMULATOR_MACHINE_EXECUTE_UNIT_MACROS_SVH

// Checked on every clock edge outside reset.
`define AMX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define AMX_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/amx_pkg.sv @@
package amx_pkg;

  localparam logic [3:0] OP_READ    = 4'd0;
  localparam logic [3:0] OP_WRITE   = 4'd1;
  localparam logic [3:0] OP_LOAD    = 4'd2;
  localparam logic [3:0] OP_STORE   = 4'd3;
  localparam logic [3:0] OP_ADD     = 4'd4;
  localparam logic [3:0] OP_SUB     = 4'd5;
  localparam logic [3:0] OP_DIV     = 4'd6;
  localparam logic [3:0] OP_MUL     = 4'd7;
  localparam logic [3:0] OP_MOD     = 4'd8;
  localparam logic [3:0] OP_POW     = 4'd9;
  localparam logic [3:0] OP_BR      = 4'd10;
  localparam logic [3:0] OP_BRNEG   = 4'd11;
  localparam logic [3:0] OP_BRPOS   = 4'd12;
  localparam logic [3:0] OP_BRZERO  = 4'd13;
  localparam logic [3:0] OP_HALT    = 4'd14;
  localparam logic [3:0] OP_INVALID = 4'd15;

  localparam logic [1:0] ST_RUN     = 2'd0;
  localparam logic [1:0] ST_HALT    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_DIVZERO = 2'd3;

  typedef struct packed {
    logic [3:0]         opcode;
    logic [6:0]         operand;
    logic signed [31:0] read_value;
  } in_item_t;

  typedef struct packed {
    logic [6:0]         next_counter;
    logic signed [31:0] accumulator_out;
    logic               write_valid;
    logic signed [31:0] write_value;
    logic [1:0]         status;
  } out_item_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_POW,
    S_FIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic capture;
    logic exec;
    logic div_step;
    logic pow_step;
    logic finish;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic go_div;
    logic go_pow;
    logic div_last;
    logic pow_last;
  } sts_t;

endpackage

@@ rtl/amx_chan_if.sv @@
interface amx_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/amx_ram.sv @@
module amx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/amx_ctrl.sv @@
`include "accumulator_machine_execute_unit_macros.svh"

module amx_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output amx_pkg::cmd_t cmd,
  input  amx_pkg::sts_t sts
);
  import amx_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.go_div)      state_next = S_DIV;
        else if (sts.go_pow) state_next = S_POW;
        else                 state_next = S_DONE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_FIN;
      end
      S_POW: begin
        cmd.pow_step = 1'b1;
        if (sts.pow_last) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
    out_valid_next = cmd.publish | (out_valid & ~out_ready);
  end

  `AMX_ASSERT_ALWAYS(a_reset_clears, rst |=> state == S_CLEAR, "reset did not start clear sweep")
  `AMX_ASSERT(a_accept_exec, (in_valid && in_ready) |=> state == S_EXEC, "accept not followed by exec")
  `AMX_ASSERT(a_publish_free, cmd.publish |-> (!out_valid || out_ready), "result overwrote beat")
  `AMX_ASSERT(a_fin_done, state == S_FIN |=> (state == S_DONE && !in_ready), "finish not published")
endmodule

@@ rtl/amx_dp.sv @@
module amx_dp #(
  parameter int DATA_WORDS    = 128,
  parameter int PROGRAM_WORDS = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  amx_pkg::cmd_t     cmd,
  output amx_pkg::sts_t     sts,
  input  amx_pkg::in_item_t in_item,
  output amx_pkg::out_item_t out_item
);
  import amx_pkg::*;

  localparam int AW = $clog2(DATA_WORDS);
  localparam int PW = $clog2(PROGRAM_WORDS);

  // operand is below 128 and the depth at least 16: a few subtracts suffice
  function automatic logic [12:0] reduce(input logic [6:0] v, input logic [12:0] d);
    logic [12:0] r;
    r = {6'b0, v};
    for (int i = 0; i < 8; i++) begin
      if (r >= d) r = r - d;
    end
    return r;
  endfunction

  logic [31:0]   acc, acc_next;
  logic [PW-1:0] pc, pc_next, pc_inc;
  logic          stopped, stopped_next;
  logic [AW-1:0] clr_addr;

  logic [3:0]    op_q;
  logic [AW-1:0] addr_q;
  logic [PW-1:0] tgt_q;
  logic [31:0]   rv_q;

  logic        res_wvalid, wvalid_n;
  logic [31:0] res_wv, wv_n;
  logic [1:0]  res_status, status_n;

  logic [31:0] quo, rem, dvs;
  logic        q_neg, r_neg, is_mod, is_pow;
  logic [32:0] rem_sh, diff;
  logic [31:0] div_res;
  logic [31:0] pw_res, pw_base, pw_exp;
  logic [4:0]  cnt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, m;
  logic [31:0]   acc_abs, m_abs;
  logic          go_div, go_pow;
  logic [PW+6:0] pc_ext;

  assign raddr = AW'(reduce(in_item.operand, 13'(DATA_WORDS)));
  assign we    = cmd.clear_step | (cmd.exec & ~stopped & (op_q == OP_READ | op_q == OP_STORE));
  assign waddr = cmd.clear_step ? clr_addr : addr_q;
  assign wdata = cmd.clear_step ? 32'd0 : ((op_q == OP_READ) ? rv_q : acc);

  amx_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (m)
  );

  assign pc_inc  = (pc == PW'(PROGRAM_WORDS - 1)) ? '0 : pc + 1'b1;
  assign acc_abs = acc[31] ? -acc : acc;
  assign m_abs   = m[31] ? -m : m;
  assign rem_sh  = {rem, quo[31]};
  assign diff    = rem_sh - {1'b0, dvs};
  assign div_res = is_mod ? (r_neg ? -rem : rem) : (q_neg ? -quo : quo);

  always_comb begin
    acc_next     = acc;
    pc_next      = pc;
    stopped_next = stopped;
    wvalid_n     = 1'b0;
    wv_n         = '0;
    status_n     = ST_RUN;
    go_div       = 1'b0;
    go_pow       = 1'b0;
    if (cmd.exec) begin
      if (stopped) begin
        status_n = ST_HALT;
      end else begin
        pc_next = pc_inc;
        unique case (op_q)
          OP_WRITE: begin
            wvalid_n = 1'b1;
            wv_n     = m;
          end
          OP_LOAD: acc_next = m;
          OP_ADD:  acc_next = acc + m;
          OP_SUB:  acc_next = acc - m;
          OP_MUL:  acc_next = acc * m;
          OP_DIV, OP_MOD: begin
            if (m == '0) begin
              status_n = ST_DIVZERO;
            end else if (acc == 32'h8000_0000 && m == '1) begin
              if (op_q == OP_MOD) acc_next = '0;
            end else begin
              go_div = 1'b1;
            end
          end
          OP_POW: begin
            if (acc[31]) begin
              if (m == 32'd1)    acc_next = 32'd1;
              else if (m == '1)  acc_next = acc[0] ? '1 : 32'd1;
              else               acc_next = '0;
            end else begin
              go_pow = 1'b1;
            end
          end
          OP_BR: pc_next = tgt_q;
          OP_BRNEG:  if (acc[31]) pc_next = tgt_q;
          OP_BRPOS:  if (acc != '0 && !acc[31]) pc_next = tgt_q;
          OP_BRZERO: if (acc == '0) pc_next = tgt_q;
          OP_HALT: begin
            status_n     = ST_HALT;
            stopped_next = 1'b1;
            pc_next      = pc;
          end
          OP_INVALID: begin
            status_n     = ST_INVALID;
            stopped_next = 1'b1;
            pc_next      = pc;
          end
          default: ;
        endcase
      end
    end
    if (cmd.finish) acc_next = is_pow ? pw_res : div_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      pc       <= '0;
      stopped  <= 1'b0;
      clr_addr <= '0;
    end else begin
      acc     <= acc_next;
      pc      <= pc_next;
      stopped <= stopped_next;
      if (cmd.clear_step) clr_addr <= clr_addr + 1'b1;
    end
  end

  assign pc_ext = (PW + 7)'(pc);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= in_item.opcode;
      addr_q <= raddr;
      tgt_q  <= PW'(reduce(in_item.operand, 13'(PROGRAM_WORDS)));
      rv_q   <= in_item.read_value;
    end
    if (cmd.exec) begin
      res_wvalid <= wvalid_n;
      res_wv     <= wv_n;
      res_status <= status_n;
      cnt        <= '0;
      is_mod     <= (op_q == OP_MOD);
      is_pow     <= go_pow;
      quo        <= acc_abs;
      rem        <= '0;
      dvs        <= m_abs;
      q_neg      <= acc[31] ^ m[31];
      r_neg      <= acc[31];
      pw_res     <= 32'd1;
      pw_base    <= m;
      pw_exp     <= acc;
    end
    if (cmd.div_step) begin
      cnt <= cnt + 1'b1;
      if (!diff[32]) begin
        rem <= diff[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= rem_sh[31:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
    if (cmd.pow_step) begin
      cnt <= cnt + 1'b1;
      if (pw_exp[0]) pw_res <= pw_res * pw_base;
      pw_base <= pw_base * pw_base;
      pw_exp  <= pw_exp >> 1;
    end
    if (cmd.publish) begin
      out_item.next_counter    <= pc_ext[6:0];
      out_item.accumulator_out <= acc;
      out_item.write_valid     <= res_wvalid;
      out_item.write_value     <= res_wv;
      out_item.status          <= res_status;
    end
  end

  assign sts.clear_last = (clr_addr == AW'(DATA_WORDS - 1));
  assign sts.go_div     = go_div;
  assign sts.go_pow     = go_pow;
  assign sts.div_last   = (cnt == 5'd31);
  assign sts.pow_last   = (cnt == 5'd30);
endmodule

@@ rtl/accumulator_machine_execute_unit.sv @@
// Execute stage of a small accumulator machine.
// instr (sink): one instruction per beat - opcode, operand and the word a
//   read instruction stores. The fetcher reads it at the counter last reported.
// result (source): one beat per instruction - next counter, accumulator,
//   write flag and word, and status (running, halted, invalid, divide by zero).
// Divide and mod run 32 steps of the shift-subtract divider, power runs
//   31 square-and-multiply steps. One instruction is in flight at a time;
//   the next is accepted once its result is registered, even while that
//   result still waits on the output.
// Reset: accumulator, counter and stop flag clear; a sweep then zeroes every
//   data memory word, one word a cycle, with instr not ready.
// Stall: a result beat holds until taken; a finished instruction waits in
//   its last state while the previous beat is still held.
// After halt or an invalid opcode every instruction is ignored and reports
//   the held state with status halted.
module accumulator_machine_execute_unit #(
  parameter int DATA_WORDS    = 128,
  parameter int PROGRAM_WORDS = 128
) (
  input logic        clk,
  input logic        rst,
  amx_chan_if.sink   instr,
  amx_chan_if.source result
);
  import amx_pkg::*;

  cmd_t cmd;
  sts_t sts;

  amx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (instr.valid),
    .in_ready  (instr.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  amx_dp #(.DATA_WORDS(DATA_WORDS), .PROGRAM_WORDS(PROGRAM_WORDS)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .in_item  (instr.data),
    .out_item (result.data)
  );
endmodule

@@ test/accumulator_machine_execute_unit_tb.sv @@
module accumulator_machine_execute_unit_tb;
  import amx_pkg::*;

  localparam int MEM_WORDS = 128;
  localparam int PROG_WORDS = 128;
  localparam int RANDOM_ITEMS = 1420;

  typedef struct {
    logic [3:0]         op;
    logic [6:0]         opnd;
    logic signed [31:0] rv;
    bit                 typed;
    logic [6:0]         nc;
    logic signed [31:0] acc;
    logic               wvld;
    logic signed [31:0] wval;
    logic [1:0]         st;
  } dir_row_t;

  logic clk;
  logic rst;

  amx_chan_if #(.T(in_item_t))  instr_if ();
  amx_chan_if #(.T(out_item_t)) result_if ();

  accumulator_machine_execute_unit #(
    .DATA_WORDS(MEM_WORDS),
    .PROGRAM_WORDS(PROG_WORDS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .instr(instr_if.sink),
    .result(result_if.source)
  );

  // Machine state as the predictor sees it.
  logic [31:0] acc_q;
  logic [6:0]  pc_q;
  logic [31:0] mem_q [MEM_WORDS];
  bit          stopped_q;

  out_item_t expected_q [$];
  int        fails;
  int        idle_pct;
  bit        hold_req;
  int        n_results;
  int        n_writes;
  int        n_divzero;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [31:0] pow_wrap(logic [31:0] base, logic [31:0] expo);
    logic [31:0] r;
    r = 32'd1;
    if (expo[31]) begin
      if (base == 32'd1) return 32'd1;
      if (base == 32'hFFFF_FFFF) return expo[0] ? 32'hFFFF_FFFF : 32'd1;
      return 32'd0;
    end
    for (int i = 0; i < 31; i++) begin
      if (expo[0]) r = r * base;
      base = base * base;
      expo = expo >> 1;
    end
    return r;
  endfunction

  function automatic out_item_t exec_instr(in_item_t it);
    out_item_t   o;
    logic [6:0]  nxt;
    logic [31:0] m;
    int          a;
    int          d;
    m = mem_q[it.operand % MEM_WORDS];
    nxt = 7'((pc_q + 1) % PROG_WORDS);
    o = '0;
    o.status = ST_RUN;
    if (stopped_q) begin
      nxt = pc_q;
      o.status = ST_HALT;
    end else begin
      case (it.opcode)
        OP_READ:  mem_q[it.operand % MEM_WORDS] = it.read_value;
        OP_WRITE: begin
          o.write_valid = 1'b1;
          o.write_value = m;
        end
        OP_LOAD:  acc_q = m;
        OP_STORE: mem_q[it.operand % MEM_WORDS] = acc_q;
        OP_ADD:   acc_q = acc_q + m;
        OP_SUB:   acc_q = acc_q - m;
        OP_MUL:   acc_q = acc_q * m;
        OP_POW:   acc_q = pow_wrap(m, acc_q);
        OP_DIV, OP_MOD: begin
          if (m == 0) begin
            o.status = ST_DIVZERO;
          end else if (acc_q == 32'h8000_0000 && m == 32'hFFFF_FFFF) begin
            if (it.opcode == OP_MOD) acc_q = 0;
          end else begin
            a = acc_q;
            d = m;
            acc_q = (it.opcode == OP_DIV) ? a / d : a % d;
          end
        end
        OP_BR:     nxt = 7'(it.operand % PROG_WORDS);
        OP_BRNEG:  if (acc_q[31]) nxt = 7'(it.operand % PROG_WORDS);
        OP_BRPOS:  if (acc_q != 0 && !acc_q[31]) nxt = 7'(it.operand % PROG_WORDS);
        OP_BRZERO: if (acc_q == 0) nxt = 7'(it.operand % PROG_WORDS);
        OP_HALT: begin
          o.status = ST_HALT;
          stopped_q = 1'b1;
          nxt = pc_q;
        end
        default: begin
          o.status = ST_INVALID;
          stopped_q = 1'b1;
          nxt = pc_q;
        end
      endcase
      pc_q = nxt;
    end
    o.next_counter = nxt;
    o.accumulator_out = acc_q;
    return o;
  endfunction

  // Directed rows; typed expectations only where they follow from reset state.
  dir_row_t dir_rows [22] = '{
    '{OP_WRITE,  7'd0,   32'sd0,          1, 7'd1,   32'sd0, 1'b1, 32'sd0, ST_RUN},
    '{OP_DIV,    7'd5,   32'sd0,          1, 7'd2,   32'sd0, 1'b0, 32'sd0, ST_DIVZERO},
    '{OP_MOD,    7'd127, 32'sd0,          1, 7'd3,   32'sd0, 1'b0, 32'sd0, ST_DIVZERO},
    '{OP_POW,    7'd9,   32'sd0,          1, 7'd4,   32'sd1, 1'b0, 32'sd0, ST_RUN},
    '{OP_READ,   7'd127, 32'h7FFF_FFFF,   1, 7'd5,   32'sd1, 1'b0, 32'sd0, ST_RUN},
    '{OP_READ,   7'd0,   32'h8000_0000,   1, 7'd6,   32'sd1, 1'b0, 32'sd0, ST_RUN},
    '{OP_READ,   7'd1,   -32'sd1,         1, 7'd7,   32'sd1, 1'b0, 32'sd0, ST_RUN},
    '{OP_LOAD,   7'd0,   32'sd0,          1, 7'd8,   32'h8000_0000, 1'b0, 32'sd0, ST_RUN},
    '{OP_DIV,    7'd1,   32'sd0,          1, 7'd9,   32'h8000_0000, 1'b0, 32'sd0, ST_RUN},
    '{OP_MOD,    7'd1,   32'sd0,          1, 7'd10,  32'sd0, 1'b0, 32'sd0, ST_RUN},
    '{OP_BRZERO, 7'd100, 32'sd0,          1, 7'd100, 32'sd0, 1'b0, 32'sd0, ST_RUN},
    '{OP_LOAD,   7'd127, 32'sd0,          0, 0, 0, 0, 0, 0},
    '{OP_ADD,    7'd127, 32'sd0,          0, 0, 0, 0, 0, 0},
    '{OP_BRNEG,  7'd5,   32'sd0,          0, 0, 0, 0, 0, 0},
    '{OP_SUB,    7'd0,   32'sd0,          0, 0, 0, 0, 0, 0},
    '{OP_BRPOS,  7'd127, 32'sd0,          0, 0, 0, 0, 0, 0},
    '{OP_MUL,    7'd127, 32'sd0,          0, 0, 0, 0, 0, 0},
    '{OP_LOAD,   7'd1,   32'sd0,          0, 0, 0, 0, 0, 0},
    '{OP_POW,    7'd1,   32'sd0,          0, 0, 0, 0, 0, 0},
    '{OP_STORE,  7'd64,  32'sd0,          0, 0, 0, 0, 0, 0},
    '{OP_WRITE,  7'd64,  32'sd0,          0, 0, 0, 0, 0, 0},
    '{OP_BR,     7'd0,   32'sd0,          0, 0, 0, 0, 0, 0}
  };

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_instr(input in_item_t it, input bit typed, input out_item_t fixed);
    out_item_t o;
    while ($urandom_range(99) < idle_pct) begin
      instr_if.valid <= 1'b0;
      @(negedge clk);
    end
    instr_if.valid <= 1'b1;
    instr_if.data <= it;
    @(posedge clk);
    while (!instr_if.ready) @(posedge clk);
    o = exec_instr(it);
    expected_q.push_back(typed ? fixed : o);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'($urandom_range(20)) - 32'd10;
      2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      3: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'd1;
      default: return 32'($urandom_range(40));
    endcase
  endfunction

  function automatic in_item_t pick_instr();
    in_item_t it;
    it.opcode = ($urandom_range(3) == 0) ? OP_READ : 4'($urandom_range(13));
    // keep most traffic on a few words so stored values get reused
    it.operand = ($urandom_range(4) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(7));
    it.read_value = pick_word();
    return it;
  endfunction

  always @(posedge clk) begin
    out_item_t e;
    out_item_t r;
    if (!rst && result_if.valid && result_if.ready) begin
      r = result_if.data;
      n_results++;
      if (r.write_valid) n_writes++;
      if (r.status == ST_DIVZERO) n_divzero++;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected");
        fails++;
      end else begin
        e = expected_q.pop_front();
        if (r.next_counter !== e.next_counter) begin
          $error("next_counter exp %0d got %0d", e.next_counter, r.next_counter);
          fails++;
        end
        if (r.accumulator_out !== e.accumulator_out) begin
          $error("accumulator_out exp %0d got %0d", e.accumulator_out, r.accumulator_out);
          fails++;
        end
        if (r.write_valid !== e.write_valid) begin
          $error("write_valid exp %0d got %0d", e.write_valid, r.write_valid);
          fails++;
        end
        if (r.write_value !== e.write_value) begin
          $error("write_value exp %0d got %0d", e.write_value, r.write_value);
          fails++;
        end
        if (r.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, r.status);
          fails++;
        end
      end
    end
  end

  // Result side: random stalls, plus one long hold when asked.
  initial begin
    int held;
    result_if.ready = 1'b0;
    held = 0;
    forever begin
      @(negedge clk);
      if (hold_req && held < 300) begin
        held++;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  initial begin
    in_item_t  it;
    out_item_t fixed;
    fails = 0;
    n_results = 0;
    n_writes = 0;
    n_divzero = 0;
    idle_pct = 35;
    hold_req = 1'b0;
    acc_q = 0;
    pc_q = 0;
    stopped_q = 1'b0;
    foreach (mem_q[i]) mem_q[i] = 0;
    rst = 1'b1;
    instr_if.valid = 1'b0;
    instr_if.data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      it.opcode = dir_rows[i].op;
      it.operand = dir_rows[i].opnd;
      it.read_value = dir_rows[i].rv;
      fixed.next_counter = dir_rows[i].nc;
      fixed.accumulator_out = dir_rows[i].acc;
      fixed.write_valid = dir_rows[i].wvld;
      fixed.write_value = dir_rows[i].wval;
      fixed.status = dir_rows[i].st;
      send_instr(it, dir_rows[i].typed, fixed);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 100) hold_req = 1'b1;
      idle_pct = (n >= 600 && n < 800) ? 0 : 35;
      send_instr(pick_instr(), 1'b0, fixed);
    end

    // Stop the machine last, then show it ignores everything after.
    it = pick_instr();
    it.opcode = $urandom_range(1) ? OP_HALT : OP_INVALID;
    send_instr(it, 1'b0, fixed);
    for (int n = 0; n < 6; n++) begin
      it = pick_instr();
      if (n == 0) it.opcode = OP_INVALID;
      if (n == 1) it.opcode = OP_READ;
      send_instr(it, 1'b0, fixed);
    end
    instr_if.valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("ran %0d instructions: %0d writes, %0d divide-by-zero, stop reached",
             n_results, n_writes, n_divzero);
    if (fails == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ accumulator_machine_execute_unit.f @@
+incdir+rtl
rtl/amx_pkg.sv
rtl/amx_chan_if.sv
rtl/amx_ram.sv
rtl/amx_ctrl.sv
rtl/amx_dp.sv
rtl/accumulator_machine_execute_unit.sv
test/accumulator_machine_execute_unit_tb.sv
